// ===== sv/fed_pkg.sv =====
// ----------------------------------------------------------------------------
// Flight event detector package
// Shared widths, operation codes, item classes and queue entry types.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int ALT_W      = 21;
  localparam int ALT100_W   = 28;
  localparam int OP_W       = 3;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_STANDBY = 3'd0;
  localparam logic [OP_W-1:0] OP_LAUNCH  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEAK    = 3'd2;
  localparam logic [OP_W-1:0] OP_LANDING = 3'd3;
  localparam logic [OP_W-1:0] OP_CAL     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd2;

  typedef enum logic [2:0] {
    KIND_IDLE,
    KIND_LAUNCH,
    KIND_PEAK,
    KIND_LAND,
    KIND_CAL
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [ALT_W-1:0]    alt;
    logic signed [ALT100_W-1:0] alt100;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

// ===== sv/fed_if.sv =====
// ----------------------------------------------------------------------------
// Flight event detector channels
// Sample input channel and flag/altitude result channel.
// ----------------------------------------------------------------------------
interface fed_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic signed [20:0] altitude;

  modport source (output valid, output op, output altitude, input ready);
  modport sink (input valid, input op, input altitude, output ready);
endinterface

interface fed_out_if;
  logic               valid;
  logic               ready;
  logic               launched;
  logic               peaked;
  logic               landed;
  logic               calibrated;
  logic signed [20:0] peak_altitude;
  logic signed [20:0] ground_altitude;

  modport source (output valid, output launched, output peaked, output landed,
                  output calibrated, output peak_altitude, output ground_altitude,
                  input ready);
  modport sink (input valid, input launched, input peaked, input landed,
                input calibrated, input peak_altitude, input ground_altitude,
                output ready);
endinterface

// ===== sv/fed_front.sv =====
// ----------------------------------------------------------------------------
// Flight event detector front end
// Accepts samples, classifies the operation and scales the altitude by 100.
// ----------------------------------------------------------------------------
module fed_front import fed_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  fed_in_if.sink  in_ch,
  input  logic    q_full,
  output q_push_t push
);

  logic   stage_valid;
  entry_t stage_entry;
  entry_t decoded;
  logic   accept;
  logic   sent;
  logic signed [ALT100_W-1:0] alt_wide;

  always_comb begin
    alt_wide = {{(ALT100_W-ALT_W){in_ch.altitude[ALT_W-1]}}, in_ch.altitude};
    decoded.alt = in_ch.altitude;
    decoded.alt100 = alt_wide * ALT100_W'(100);
    case (in_ch.op)
      OP_LAUNCH:  decoded.kind = KIND_LAUNCH;
      OP_PEAK:    decoded.kind = KIND_PEAK;
      OP_LANDING: decoded.kind = KIND_LAND;
      OP_CAL:     decoded.kind = KIND_CAL;
      default:    decoded.kind = KIND_IDLE;
    endcase
  end

  assign sent = stage_valid && !q_full;
  assign in_ch.ready = !stage_valid || !q_full;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (sent) begin
      stage_valid <= 1'b0;
    end
    if (accept) begin
      stage_entry <= decoded;
    end
  end

  assign push.valid = sent;
  assign push.entry = stage_entry;

endmodule

// ===== sv/fed_queue.sv =====
// ----------------------------------------------------------------------------
// Flight event detector queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fed_queue import fed_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_push_t push,
  output logic    full,
  output q_head_t head,
  input  logic    pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_pop = pop && head.valid;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push.valid && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push.valid && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

// ===== sv/fed_back.sv =====
// ----------------------------------------------------------------------------
// Flight event detector back end
// Holds the flight state and settings, runs each check and registers results.
// ----------------------------------------------------------------------------
module fed_back import fed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_en,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  input  q_head_t              head,
  output logic                 pop,
  fed_out_if.source            out_ch
);

  localparam logic [3:0]  CAL_LAST   = 4'd9;
  localparam logic [3:0]  PEAK_COUNT = 4'd10;
  localparam logic [3:0]  DESC_MAX   = 4'd15;
  localparam logic [2:0]  STABLE_MAX = 3'd7;
  localparam logic [2:0]  LAND_WINS  = 3'd3;
  localparam logic [31:0] WINDOW_MS  = 32'd2000;
  localparam logic [23:0] RECIP10    = 24'd13421773;
  localparam int          SUM_W      = 25;

  logic [CFG_W-1:0] launch_thr;
  logic [CFG_W-1:0] landing_thr;
  logic [CFG_W-1:0] period;

  logic signed [ALT_W-1:0] base_alt, base_alt_next;
  logic signed [SUM_W-1:0] cal_sum, cal_sum_next;
  logic [3:0]              cal_count, cal_count_next;
  logic signed [ALT_W-1:0] max_alt, max_alt_next;
  logic [3:0]              descent_count, descent_count_next;
  logic signed [ALT_W-1:0] landing_ref, landing_ref_next;
  logic [15:0]             window_ticks, window_ticks_next;
  logic [2:0]              stable_count, stable_count_next;
  logic                    launched, launched_next;
  logic                    peaked, peaked_next;
  logic                    landed, landed_next;
  logic                    calibrated, calibrated_next;

  logic                       out_valid;
  logic signed [ALT_W-1:0]    alt;
  logic signed [SUM_W-1:0]    sum_add;
  logic [SUM_W-1:0]           sum_mag;
  logic [47:0]                div_prod;
  logic [ALT_W-1:0]           div_q;
  logic signed [22:0]         launch_limit;
  logic signed [ALT100_W-1:0] max99;
  logic [15:0]                ticks_inc;
  logic [31:0]                window_len;
  logic signed [ALT_W:0]      diff;
  logic [ALT_W:0]             diff_mag;
  logic [3:0]                 desc_tmp;
  logic [2:0]                 stable_tmp;

  assign pop = head.valid && (!out_valid || out_ch.ready);
  assign alt = head.entry.alt;

  always_comb begin
    sum_add = cal_sum + {{(SUM_W-ALT_W){alt[ALT_W-1]}}, alt};
    sum_mag = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    div_prod = sum_mag[23:0] * RECIP10;
    div_q = div_prod[47:27];
    launch_limit = 23'(base_alt) + $signed({7'd0, launch_thr});
    max99 = ALT100_W'(max_alt) * ALT100_W'(99);
    ticks_inc = (window_ticks != 16'hFFFF) ? window_ticks + 16'd1 : window_ticks;
    window_len = period * ticks_inc;
    diff = (ALT_W+1)'(alt) - (ALT_W+1)'(landing_ref);
    diff_mag = diff[ALT_W] ? (ALT_W+1)'(-diff) : (ALT_W+1)'(diff);
    desc_tmp = descent_count;
    stable_tmp = stable_count;

    base_alt_next      = base_alt;
    cal_sum_next       = cal_sum;
    cal_count_next     = cal_count;
    max_alt_next       = max_alt;
    descent_count_next = descent_count;
    landing_ref_next   = landing_ref;
    window_ticks_next  = window_ticks;
    stable_count_next  = stable_count;
    launched_next      = launched;
    peaked_next        = peaked;
    landed_next        = landed;
    calibrated_next    = calibrated;

    case (head.entry.kind)
      KIND_CAL: begin
        if (cal_count == CAL_LAST) begin
          base_alt_next   = sum_add[SUM_W-1] ? ALT_W'(-div_q) : ALT_W'(div_q);
          cal_sum_next    = '0;
          cal_count_next  = '0;
          calibrated_next = 1'b1;
        end else begin
          cal_sum_next   = sum_add;
          cal_count_next = cal_count + 4'd1;
        end
      end
      KIND_LAUNCH: begin
        if (23'(alt) > launch_limit) begin
          launched_next = 1'b1;
        end
      end
      KIND_PEAK: begin
        if (alt > max_alt) begin
          max_alt_next = alt;
          desc_tmp = '0;
        end else if (head.entry.alt100 < max99) begin
          if (descent_count < DESC_MAX) begin
            desc_tmp = descent_count + 4'd1;
          end
        end
        descent_count_next = desc_tmp;
        if (desc_tmp == PEAK_COUNT) begin
          peaked_next = 1'b1;
          landing_ref_next = alt;
        end
      end
      KIND_LAND: begin
        window_ticks_next = ticks_inc;
        if (window_len > WINDOW_MS) begin
          window_ticks_next = '0;
          if (diff_mag < {6'd0, landing_thr}) begin
            if (stable_count < STABLE_MAX) begin
              stable_tmp = stable_count + 3'd1;
            end
          end
          stable_count_next = stable_tmp;
          landing_ref_next = alt;
          if (stable_tmp > LAND_WINS) begin
            landed_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_thr    <= 16'd100;
      landing_thr   <= 16'd20;
      period        <= 16'd100;
      base_alt      <= '0;
      cal_sum       <= '0;
      cal_count     <= '0;
      max_alt       <= '0;
      descent_count <= '0;
      landing_ref   <= '0;
      window_ticks  <= '0;
      stable_count  <= '0;
      launched      <= 1'b0;
      peaked        <= 1'b0;
      landed        <= 1'b0;
      calibrated    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (write_en) begin
        case (write_index)
          REG_LAUNCH_THR:  launch_thr <= write_data;
          REG_LANDING_THR: landing_thr <= write_data;
          REG_PERIOD:      period <= write_data;
          default: begin
          end
        endcase
      end
      if (pop) begin
        base_alt      <= base_alt_next;
        cal_sum       <= cal_sum_next;
        cal_count     <= cal_count_next;
        max_alt       <= max_alt_next;
        descent_count <= descent_count_next;
        landing_ref   <= landing_ref_next;
        window_ticks  <= window_ticks_next;
        stable_count  <= stable_count_next;
        launched      <= launched_next;
        peaked        <= peaked_next;
        landed        <= landed_next;
        calibrated    <= calibrated_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.launched        = launched;
  assign out_ch.peaked          = peaked;
  assign out_ch.landed          = landed;
  assign out_ch.calibrated      = calibrated;
  assign out_ch.peak_altitude   = max_alt;
  assign out_ch.ground_altitude = base_alt;

endmodule

// ===== sv/flight_event_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Flight event detector
// Detects calibration, launch, apogee and landing from altitude samples.
//
//   Port         Direction  Contents
//   in_ch        sink       op, altitude
//   out_ch       source     launched, peaked, landed, calibrated,
//                           peak_altitude, ground_altitude
//   write_*      input      register index and data
//
// A sample passes the front register, a two-entry queue and the back end,
// whose output register offers its result on out_ch.
// The back end updates all of its flight state together when it pops a sample.
// One sample is taken per cycle unless a full queue stalls the front register.
// Reset is synchronous and restores every flag, counter and register default.
// A stalled output holds the back end, and the queue then fills and stalls
// the input.
// ----------------------------------------------------------------------------
module flight_event_detector_unit import fed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_en,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  fed_in_if.sink               in_ch,
  fed_out_if.source            out_ch
);

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  fed_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  fed_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  fed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .head        (head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule
